// ----- sv/assert_macros.svh -----
// Assertion macros shared by the promotable priority table RTL.
// No dependencies; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/ppt_pkg.sv -----
// Package of the promotable priority table: field widths, codes and the
// structs passed between the sequencer and the slot cells. No dependencies.
`default_nettype none

package ppt_pkg;

  localparam int ACTION_W = 3;
  localparam int ID_W     = 4;
  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 16;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [PRIO_W-1:0]  PRIO_MAX    = '1;
  localparam logic [STAMP_W-1:0] STAMP_LIMIT = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD      = 3'd0,
    ACT_PROMOTE  = 3'd1,
    ACT_GET_MAX  = 3'd2,
    ACT_POP_MAX  = 3'd3,
    ACT_IS_VALID = 3'd4,
    ACT_GET      = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  // Request broadcast to every cell for the duration of one scan.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     slot_id;
    logic [DATA_W-1:0]   data;
    logic [STAMP_W-1:0]  stamp;
    logic                add_ok;
  } req_t;

  // Running record handed from cell to cell.
  typedef struct packed {
    logic               found;
    logic [DATA_W-1:0]  data;
    logic [PRIO_W-1:0]  prio;
    logic [STAMP_W-1:0] stamp;
  } carry_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   item_id;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
    logic              id_valid;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/ppt_if.sv -----
// Valid/ready channel interfaces of the promotable priority table.
// Depends on ppt_pkg for the field widths.
`default_nettype none

interface ppt_in_if import ppt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     slot_id;
  logic [DATA_W-1:0]   data_value;

  modport source (output valid, action, slot_id, data_value, input ready);
  modport sink (input valid, action, slot_id, data_value, output ready);
endinterface

interface ppt_out_if import ppt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     item_id;
  logic [DATA_W-1:0]   data_out;
  logic [PRIO_W-1:0]   priority_out;
  logic                id_valid;

  modport source (output valid, status, item_id, data_out, priority_out, id_valid,
                  input ready);
  modport sink (input valid, status, item_id, data_out, priority_out, id_valid,
                output ready);
endinterface

`default_nettype wire

// ----- sv/ppt_cell.sv -----
// One slot of the table: holds the item and updates the running record
// when the scan token passes through it. Depends on ppt_pkg.
`default_nettype none

module ppt_cell import ppt_pkg::*; #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire req_t             req_i,
  input  wire logic             tok_i,
  input  wire carry_t           carry_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic             clr_en_i,
  input  wire logic [IDX_W-1:0] clr_idx_i,
  output logic                  tok_o,
  output carry_t                carry_o,
  output logic [IDX_W-1:0]      idx_o
);

  localparam logic [31:0]      CellIdx  = 32'(CELL_IDX);
  localparam logic [IDX_W-1:0] CellAddr = IDX_W'(CELL_IDX);

  logic               in_use_q, in_use_d;
  logic [DATA_W-1:0]  data_q, data_d;
  logic [PRIO_W-1:0]  prio_q, prio_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic               tok_q;
  carry_t             carry_q, carry_d;
  logic [IDX_W-1:0]   idx_q, idx_d;

  logic   hit;
  logic   wins;
  carry_t mine;

  assign hit  = (32'(req_i.slot_id) == CellIdx) && in_use_q;
  assign mine = '{found: 1'b1, data: data_q, prio: prio_q, stamp: stamp_q};
  assign wins = in_use_q && (!carry_i.found || (prio_q > carry_i.prio) ||
                ((prio_q == carry_i.prio) && (stamp_q > carry_i.stamp)));

  always_comb begin
    in_use_d = in_use_q;
    data_d   = data_q;
    prio_d   = prio_q;
    stamp_d  = stamp_q;
    carry_d  = carry_i;
    idx_d    = idx_i;
    if (tok_i) begin
      case (action_e'(req_i.action))
        ACT_ADD: begin
          if (!carry_i.found && !in_use_q && req_i.add_ok) begin
            in_use_d = 1'b1;
            data_d   = req_i.data;
            prio_d   = '0;
            stamp_d  = req_i.stamp;
            carry_d  = '{found: 1'b1, data: req_i.data, prio: '0, stamp: req_i.stamp};
            idx_d    = CellAddr;
          end
        end
        ACT_PROMOTE: begin
          if (hit) begin
            prio_d        = (prio_q == PRIO_MAX) ? prio_q : prio_q + 1'b1;
            carry_d       = mine;
            carry_d.prio  = prio_d;
            idx_d         = CellAddr;
          end
        end
        ACT_IS_VALID, ACT_GET: begin
          if (hit) begin
            carry_d = mine;
            idx_d   = CellAddr;
          end
        end
        ACT_GET_MAX, ACT_POP_MAX: begin
          if (wins) begin
            carry_d = mine;
            idx_d   = CellAddr;
          end
        end
        default: begin
          carry_d = carry_i;
        end
      endcase
    end
    if (clr_en_i && (clr_idx_i == CellAddr)) begin
      in_use_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
      tok_q    <= 1'b0;
    end else begin
      in_use_q <= in_use_d;
      tok_q    <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    prio_q  <= prio_d;
    stamp_q <= stamp_d;
    carry_q <= carry_d;
    idx_q   <= idx_d;
  end

  assign tok_o   = tok_q;
  assign carry_o = carry_q;
  assign idx_o   = idx_q;

endmodule

`default_nettype wire

// ----- sv/ppt_ctrl.sv -----
// Sequencer of the promotable priority table: takes a transaction, launches
// the scan through the cell chain, forms the result and holds the output.
// Depends on ppt_pkg.
`default_nettype none

module ppt_ctrl import ppt_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ACTION_W-1:0] in_action_i,
  input  wire logic [ID_W-1:0]     in_slot_id_i,
  input  wire logic [DATA_W-1:0]   in_data_i,
  output req_t                     req_o,
  output logic                     start_o,
  input  wire logic                last_tok_i,
  input  wire carry_t              last_carry_i,
  input  wire logic [IDX_W-1:0]    last_idx_i,
  output logic                     clr_en_o,
  output logic [IDX_W-1:0]         clr_idx_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output res_t                     res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic               start_q, start_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic               out_valid_q, out_valid_d;
  req_t               req_q, req_d;
  res_t               pend_q, pend_d;
  res_t               out_q, out_d;
  res_t               res_c;
  logic               accept;
  logic               out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    res_c = '{status: ST_OK, item_id: '0, data: '0, prio: '0, id_valid: 1'b0};
    case (action_e'(req_q.action))
      ACT_ADD: begin
        if (last_carry_i.found) begin
          res_c = '{status: ST_OK, item_id: ID_W'(last_idx_i), data: last_carry_i.data,
                    prio: '0, id_valid: 1'b1};
        end else begin
          res_c.status = ST_FULL;
        end
      end
      ACT_PROMOTE, ACT_GET, ACT_IS_VALID: begin
        res_c.item_id = req_q.slot_id;
        if (last_carry_i.found) begin
          res_c.data     = last_carry_i.data;
          res_c.prio     = last_carry_i.prio;
          res_c.id_valid = 1'b1;
        end else if (req_q.action != ACT_IS_VALID) begin
          res_c.status = ST_UNUSED;
        end
      end
      ACT_GET_MAX, ACT_POP_MAX: begin
        if (last_carry_i.found) begin
          res_c = '{status: ST_OK, item_id: ID_W'(last_idx_i), data: last_carry_i.data,
                    prio: last_carry_i.prio, id_valid: 1'b1};
        end else begin
          res_c.status = ST_EMPTY;
        end
      end
      default: begin
        res_c.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    stamp_d     = stamp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    req_d       = req_q;
    pend_d      = pend_q;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = '{action: in_action_i, slot_id: in_slot_id_i, data: in_data_i,
                      stamp: stamp_q, add_ok: (stamp_q != STAMP_LIMIT)};
          start_d = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_tok_i) begin
          pend_d  = res_c;
          state_d = S_HOLD;
          if ((req_q.action == ACT_ADD) && last_carry_i.found) begin
            stamp_d = stamp_q + 1'b1;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign req_o       = req_q;
  assign start_o     = start_q;
  assign clr_en_o    = (state_q == S_SCAN) && last_tok_i &&
                       (req_q.action == ACT_POP_MAX) && last_carry_i.found;
  assign clr_idx_o   = last_idx_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ----- sv/promotable_priority_table_unit.sv -----
// Promotable priority table: top level with the sequencer and a chain of
// SLOTS slot cells. Depends on ppt_pkg, ppt_if, ppt_ctrl, ppt_cell and
// assert_macros.svh.
//
// Usage: req_i carries one operation per transaction (add, promote, get max,
// pop max, is valid, get) with a slot id and a data word. rsp_o returns exactly
// one result transaction per request, in order: status, item id, data,
// priority and a slot-valid flag. Slot ids stay fixed while an item lives.
// Every operation sends a token down the cell chain, one cell per cycle, which
// carries the running best entry, the matching slot or the first free slot.
// The sequencer captures the result when the token leaves the last cell and
// moves it to the output register; a new request is taken only after that,
// so one transaction at a time is in the table. A finished result waits in
// the output register; the next request is accepted while it waits, and its
// result then holds in the sequencer until rsp_o is free. Reset empties every
// slot and clears the stamp counter; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module promotable_priority_table_unit import ppt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ppt_in_if.sink    req_i,
  ppt_out_if.source rsp_o
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [SLOTS:0]   tok;
  carry_t           carry [SLOTS+1];
  logic [IDX_W-1:0] idx [SLOTS+1];
  req_t             req;
  logic             clr_en;
  logic [IDX_W-1:0] clr_idx;
  res_t             res;

  ppt_ctrl #(.IDX_W(IDX_W)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_action_i (req_i.action),
    .in_slot_id_i(req_i.slot_id),
    .in_data_i   (req_i.data_value),
    .req_o       (req),
    .start_o     (tok[0]),
    .last_tok_i  (tok[SLOTS]),
    .last_carry_i(carry[SLOTS]),
    .last_idx_i  (idx[SLOTS]),
    .clr_en_o    (clr_en),
    .clr_idx_o   (clr_idx),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .res_o       (res)
  );

  assign carry[0] = '{found: 1'b0, data: '0, prio: '0, stamp: '0};
  assign idx[0]   = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ppt_cell #(.IDX_W(IDX_W), .CELL_IDX(i)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req),
      .tok_i    (tok[i]),
      .carry_i  (carry[i]),
      .idx_i    (idx[i]),
      .clr_en_i (clr_en),
      .clr_idx_i(clr_idx),
      .tok_o    (tok[i+1]),
      .carry_o  (carry[i+1]),
      .idx_o    (idx[i+1])
    );
  end

  assign rsp_o.status       = res.status;
  assign rsp_o.item_id      = res.item_id;
  assign rsp_o.data_out     = res.data;
  assign rsp_o.priority_out = res.prio;
  assign rsp_o.id_valid     = res.id_valid;

  `ASSERT_ALWAYS(a_single_token, $onehot0(tok), "More than one scan token in the chain.")
  `ASSERT_CLK(a_idle_no_scan, req_i.ready |-> (tok == '0), "Request taken during a scan.")
  `ASSERT_CLK(a_valid_is_ok, (rsp_o.valid && rsp_o.id_valid) |-> (rsp_o.status == ST_OK),
              "Valid slot reported with an error status.")

endmodule

`default_nettype wire

// ----- tb/ppt_result_checker.sv -----
// Scoreboard for the promotable priority table: keeps its own copy of the slot
// table, predicts one result per request transaction and checks each result.
// Depends on ppt_pkg and the channel interfaces in ppt_if.
`timescale 1ns / 100ps

module ppt_result_checker import ppt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ppt_in_if                req_mon,
  ppt_out_if               rsp_mon,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output logic [SLOTS-1:0] live_mask_o
);

  logic [SLOTS-1:0]   slot_used;
  logic [DATA_W-1:0]  slot_word [SLOTS];
  logic [PRIO_W-1:0]  slot_prio [SLOTS];
  logic [STAMP_W-1:0] slot_order [SLOTS];
  logic [STAMP_W-1:0] stamp_ctr;

  res_t table_answers_q [$];
  res_t want;
  int   mismatches;
  int   checked;

  function automatic res_t predict_table_op(input logic [ACTION_W-1:0] act,
                                            input logic [ID_W-1:0] sid,
                                            input logic [DATA_W-1:0] dval);
    res_t r;
    int   pick;
    logic live;
    r = '0;
    r.status = ST_OK;
    pick = -1;
    live = (int'(sid) < SLOTS) && slot_used[sid];
    case (act)
      ACT_ADD: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_used[i]) pick = i;
        end
        if (pick < 0 || stamp_ctr == STAMP_LIMIT) begin
          r.status = ST_FULL;
        end else begin
          slot_used[pick]  = 1'b1;
          slot_word[pick]  = dval;
          slot_prio[pick]  = '0;
          slot_order[pick] = stamp_ctr;
          stamp_ctr        = stamp_ctr + 1'b1;
          r.item_id  = pick[ID_W-1:0];
          r.data     = dval;
          r.id_valid = 1'b1;
        end
      end
      ACT_PROMOTE, ACT_GET, ACT_IS_VALID: begin
        r.item_id = sid;
        if (live) begin
          if (act == ACT_PROMOTE && slot_prio[sid] != PRIO_MAX) begin
            slot_prio[sid] = slot_prio[sid] + 1'b1;
          end
          r.data     = slot_word[sid];
          r.prio     = slot_prio[sid];
          r.id_valid = 1'b1;
        end else if (act != ACT_IS_VALID) begin
          r.status = ST_UNUSED;
        end
      end
      ACT_GET_MAX, ACT_POP_MAX: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && (pick < 0 || slot_prio[i] > slot_prio[pick] ||
              (slot_prio[i] == slot_prio[pick] && slot_order[i] > slot_order[pick]))) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.item_id  = pick[ID_W-1:0];
          r.data     = slot_word[pick];
          r.prio     = slot_prio[pick];
          r.id_valid = 1'b1;
          if (act == ACT_POP_MAX) slot_used[pick] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                             input logic [DATA_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used = '0;
      stamp_ctr = '0;
      mismatches = 0;
      checked = 0;
      table_answers_q.delete();
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        table_answers_q.push_back(predict_table_op(req_mon.action, req_mon.slot_id,
                                                   req_mon.data_value));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (table_answers_q.size() == 0) begin
          $error("Result transaction arrived with no request outstanding.");
          mismatches++;
        end else begin
          want = table_answers_q.pop_front();
          checked++;
          check_field("status", DATA_W'(want.status), DATA_W'(rsp_mon.status));
          check_field("item_id", DATA_W'(want.item_id), DATA_W'(rsp_mon.item_id));
          check_field("data_out", want.data, rsp_mon.data_out);
          check_field("priority_out", DATA_W'(want.prio), DATA_W'(rsp_mon.priority_out));
          check_field("id_valid", DATA_W'(want.id_valid), DATA_W'(rsp_mon.id_valid));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= table_answers_q.size();
    checked_o    <= checked;
    live_mask_o  <= slot_used;
  end

endmodule

// ----- tb/promotable_priority_table_unit_tb.sv -----
// Top of the promotable priority table testbench: clock, reset, request and
// result stimulus with random gaps, watchdog and verdict. Depends on ppt_pkg,
// ppt_if, ppt_result_checker and the promotable_priority_table_unit RTL.
`timescale 1ns / 100ps

module promotable_priority_table_unit_tb;
  import ppt_pkg::*;

  localparam int SLOTS       = 16;
  localparam int IDLE_LIMIT  = 2000;
  localparam int BLOCKS      = 14;
  localparam int BLOCK_LEN   = 50;
  localparam int PROMOTE_RUN = 8;

  localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_PROMOTE, MIX_EVEN} mix_e;

  logic clk;
  logic rst_n;
  bit   calm;
  int   op_count [8];

  int               fail_count;
  int               pending;
  int               checked;
  logic [SLOTS-1:0] live_mask;

  ppt_in_if  req_if ();
  ppt_out_if rsp_if ();

  promotable_priority_table_unit #(.SLOTS(SLOTS)) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  ppt_result_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .live_mask_o (live_mask)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom();
  endfunction

  function automatic logic [ID_W-1:0] pick_slot();
    logic [ID_W-1:0] cand [$];
    logic [ID_W-1:0] any_id;
    any_id = ID_W'($urandom_range(0, SLOTS - 1));
    if (live_mask == '0 || $urandom_range(0, 4) == 0) return any_id;
    for (int i = 0; i < SLOTS; i++) begin
      if (live_mask[i]) cand.push_back(ID_W'(i));
    end
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(input mix_e mix);
    int roll;
    int add_w;
    int pro_w;
    int pop_w;
    roll  = $urandom_range(0, 99);
    add_w = (mix == MIX_FILL) ? 45 : (mix == MIX_DRAIN) ? 15 : 25;
    pro_w = (mix == MIX_PROMOTE) ? 40 : 20;
    pop_w = (mix == MIX_DRAIN) ? 35 : 10;
    if (roll < add_w) return ACT_ADD;
    if (roll < add_w + pro_w) return ACT_PROMOTE;
    if (roll < add_w + pro_w + pop_w) return ACT_POP_MAX;
    roll = $urandom_range(0, 19);
    if (roll < 6) return ACT_GET_MAX;
    if (roll < 12) return ACT_IS_VALID;
    if (roll < 18) return ACT_GET;
    return (roll == 18) ? ACT_RSVD6 : ACT_RSVD7;
  endfunction

  task automatic send_op(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] sid,
                         input logic [DATA_W-1:0] dval);
    int gap;
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.slot_id    <= sid;
    req_if.data_value <= dval;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    op_count[act]++;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    mix_e mix;
    calm = 1'b0;
    rst_n <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_ADD;
    req_if.slot_id    <= '0;
    req_if.data_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, unused slots, tie on priorities, slot reuse and undefined codes.
    send_op(ACT_GET_MAX, 4'd0, 32'h0);
    send_op(ACT_POP_MAX, 4'd0, 32'h0);
    send_op(ACT_GET, 4'd0, 32'h0);
    send_op(ACT_PROMOTE, 4'd15, 32'hFFFF_FFFF);
    send_op(ACT_IS_VALID, 4'd10, 32'h0);
    send_op(ACT_ADD, 4'd0, 32'h0000_0000);
    send_op(ACT_ADD, 4'd15, 32'hFFFF_FFFF);
    send_op(ACT_ADD, 4'd7, 32'hA5A5_A5A5);
    send_op(ACT_GET_MAX, 4'd0, 32'h0);
    send_op(ACT_PROMOTE, 4'd0, 32'h0);
    send_op(ACT_GET_MAX, 4'd0, 32'h0);
    send_op(ACT_IS_VALID, 4'd1, 32'h0);
    send_op(ACT_GET, 4'd2, 32'h0);
    send_op(ACT_POP_MAX, 4'd0, 32'h0);
    send_op(ACT_ADD, 4'd0, 32'h5A5A_5A5A);
    send_op(ACT_IS_VALID, 4'd0, 32'h0);
    send_op(ACT_PROMOTE, 4'd2, 32'h0);
    send_op(ACT_PROMOTE, 4'd1, 32'h0);
    send_op(ACT_GET_MAX, 4'd0, 32'h0);
    send_op(ACT_RSVD6, 4'd15, 32'hFFFF_FFFF);
    send_op(ACT_RSVD7, 4'd0, 32'h0);

    wait_drained();
    for (int i = 0; i <= SLOTS; i++) send_op(ACT_ADD, pick_slot(), pick_data());

    for (int blk = 0; blk < BLOCKS; blk++) begin
      mix  = mix_e'($urandom_range(0, 3));
      calm = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < BLOCK_LEN; k++) begin
        send_op(pick_action(mix), pick_slot(), pick_data());
      end
      if (blk == BLOCKS / 2 || $urandom_range(0, 3) == 0) wait_drained();
    end

    // Promote the older entry well past a newer one at priority zero.
    calm = 1'b1;
    for (int i = 0; i <= SLOTS; i++) send_op(ACT_POP_MAX, pick_slot(), pick_data());
    send_op(ACT_ADD, 4'd0, pick_data());
    send_op(ACT_ADD, 4'd0, pick_data());
    repeat (PROMOTE_RUN) send_op(ACT_PROMOTE, 4'd0, pick_data());
    send_op(ACT_GET_MAX, 4'd0, 32'h0);
    send_op(ACT_POP_MAX, 4'd0, 32'h0);
    send_op(ACT_GET, 4'd0, 32'h0);
    send_op(ACT_POP_MAX, 4'd0, 32'h0);
    calm = 1'b0;

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    $display("Covered %0d add, %0d promote, %0d get-max, %0d pop-max, %0d is-valid, %0d get",
             op_count[ACT_ADD], op_count[ACT_PROMOTE], op_count[ACT_GET_MAX],
             op_count[ACT_POP_MAX], op_count[ACT_IS_VALID], op_count[ACT_GET]);
    $display("and %0d undefined requests with a promotion run; %0d results checked.",
             op_count[ACT_RSVD6] + op_count[ACT_RSVD7], checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
